[hdl/mhs_pkg.sv]
// ----------------------------------------------------------------------------
// mhs_pkg: shared definitions for the min-heap sorter
// Capacity, derived widths, the controller state encoding and the structs
// that carry memory requests and results between the modules.
// ----------------------------------------------------------------------------
package mhs_pkg;

    // Heap capacity in entries, from 2 to 64.
    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 1;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UP_CMP,
        ST_UP_FIN,
        ST_D_ROOT,
        ST_D_TAIL,
        ST_D_EMIT,
        ST_SD_LEFT,
        ST_SD_RIGHT,
        ST_SD_CMP
    } t_state;

    // One write port and one read port of the heap memory.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // One result offered to the output register.
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] value;
        logic              last;
        logic              ovf;
    } t_res;

endpackage

[hdl/min_heap_sorter.sv]
// Insert: a value into an empty heap is written directly; otherwise it climbs the heap
// with a sift-up walk, and the input stalls until the insert is done.
// Drain: each result is taken from the root and the heap is restored by a sift-down
// walk, whose pace is set by the single read port.
// Reset (synchronous, active low) empties the heap and clears overflow.
// ----------------------------------------------------------------------------
// min_heap_sorter: binary min-heap sorter
// Collects values into a heap memory and, after the item marked last,
// emits them in ascending order through a registered output stage.
// ----------------------------------------------------------------------------
module min_heap_sorter (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [mhs_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [mhs_pkg::DATA_W-1:0] o_sorted_value,
    output logic                       o_last_res,
    output logic                       o_overflow
);
    import mhs_pkg::*;

    t_ram_req          ram_req;
    t_res              res;
    logic [DATA_W-1:0] rdata;
    logic              res_ready;
    logic              r_ovalid;
    logic [DATA_W-1:0] r_oval;
    logic              r_olast;
    logic              r_oovf;

    // Heap memory.
    mhs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rdata)
    );

    // Heap sequencer.
    mhs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_value     (i_value),
        .i_last      (i_last),
        .o_stall     (o_stall),
        .o_ram       (ram_req),
        .i_rdata     (rdata),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // The output register takes a result when empty or when its transfer completes.
    assign res_ready = !r_ovalid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (res.valid) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid) begin
            r_oval  <= res.value;
            r_olast <= res.last;
            r_oovf  <= res.ovf;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_sorted_value = r_oval;
    assign o_last_res     = r_olast;
    assign o_overflow     = r_oovf;

endmodule

[hdl/mhs_ram.sv]
// ----------------------------------------------------------------------------
// mhs_ram: generic simple dual-port RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module mhs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mhs_ctrl.sv]
// ----------------------------------------------------------------------------
// mhs_ctrl: heap sequencer
// Inserts values with a sift-up walk and drains the heap with root
// extraction and a sift-down walk, one heap level at a time.
// ----------------------------------------------------------------------------
module mhs_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic [mhs_pkg::DATA_W-1:0] i_value,
    input  logic                       i_last,
    output logic                       o_stall,
    output mhs_pkg::t_ram_req          o_ram,
    input  logic [mhs_pkg::DATA_W-1:0] i_rdata,
    output mhs_pkg::t_res              o_res,
    input  logic                       i_res_ready
);
    import mhs_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_ovf, n_ovf;
    logic                r_last, n_last;
    logic [ADDR_W-1:0]   r_pos, n_pos;
    logic [DATA_W-1:0]   r_val, n_val;
    logic [DATA_W-1:0]   r_top, n_top;
    logic [DATA_W-1:0]   r_lval, n_lval;
    logic                r_has_rc, n_has_rc;

    logic                accept;
    logic                full;
    logic [ADDR_W-1:0]   parent;
    logic [ADDR_W-1:0]   cnt_parent;
    logic [CHILD_W-1:0]  lc;
    logic [CHILD_W-1:0]  rc;
    logic [CHILD_W-1:0]  size_ext;
    logic                pick_right;
    logic [DATA_W-1:0]   pick_val;
    logic [ADDR_W-1:0]   pick_idx;
    logic [CNT_W-1:0]    cnt_dec;

    assign accept     = i_valid && (r_state == ST_IDLE);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign parent     = (r_pos - ADDR_W'(1)) >> 1;
    assign cnt_parent = (r_count[ADDR_W-1:0] - ADDR_W'(1)) >> 1;
    assign lc         = {r_pos, 1'b1};
    assign rc         = lc + CHILD_W'(1);
    assign size_ext   = CHILD_W'(r_count);
    assign cnt_dec    = r_count - CNT_W'(1);

    // Child selection: ties go to the right child.
    assign pick_right = r_has_rc && !(r_lval < i_rdata);
    assign pick_val   = pick_right ? i_rdata : r_lval;
    assign pick_idx   = pick_right ? rc[ADDR_W-1:0] : lc[ADDR_W-1:0];

    assign o_stall = (r_state != ST_IDLE);

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_last  <= n_last;
        end
    end

    // Working registers of the current walk.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_val    <= n_val;
        r_top    <= n_top;
        r_lval   <= n_lval;
        r_has_rc <= n_has_rc;
    end

    // Next state, memory requests and results.
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ovf    = r_ovf;
        n_last   = r_last;
        n_pos    = r_pos;
        n_val    = r_val;
        n_top    = r_top;
        n_lval   = r_lval;
        n_has_rc = r_has_rc;
        o_ram    = '0;
        o_res    = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_last = i_last;
                    n_val  = i_value;
                    if (full) begin
                        // Heap full: drop the value but still honor last.
                        n_ovf = 1'b1;
                        if (i_last) begin
                            n_state = ST_D_ROOT;
                        end
                    end else begin
                        n_count = r_count + CNT_W'(1);
                        n_pos   = r_count[ADDR_W-1:0];
                        if (r_count == '0) begin
                            o_ram.we    = 1'b1;
                            o_ram.waddr = '0;
                            o_ram.wdata = i_value;
                            if (i_last) begin
                                n_state = ST_D_ROOT;
                            end
                        end else begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = cnt_parent;
                            n_state     = ST_UP_CMP;
                        end
                    end
                end
            end

            ST_UP_CMP: begin
                if (r_val < i_rdata) begin
                    // Move the parent down into the hole.
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = i_rdata;
                    n_pos       = parent;
                    if (parent == '0) begin
                        n_state = ST_UP_FIN;
                    end else begin
                        o_ram.re    = 1'b1;
                        o_ram.raddr = (parent - ADDR_W'(1)) >> 1;
                    end
                end else begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = r_val;
                    n_state     = r_last ? ST_D_ROOT : ST_IDLE;
                end
            end

            ST_UP_FIN: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = '0;
                o_ram.wdata = r_val;
                n_state     = r_last ? ST_D_ROOT : ST_IDLE;
            end

            ST_D_ROOT: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = '0;
                n_state     = ST_D_TAIL;
            end

            ST_D_TAIL: begin
                n_top       = i_rdata;
                o_ram.re    = 1'b1;
                o_ram.raddr = cnt_dec[ADDR_W-1:0];
                n_state     = ST_D_EMIT;
            end

            ST_D_EMIT: begin
                if (i_res_ready) begin
                    o_res.valid = 1'b1;
                    o_res.value = r_top;
                    o_res.last  = (cnt_dec == '0);
                    o_res.ovf   = r_ovf;
                    n_count     = cnt_dec;
                    n_val       = i_rdata;
                    n_pos       = '0;
                    if (cnt_dec == '0) begin
                        n_ovf   = 1'b0;
                        n_last  = 1'b0;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_SD_LEFT;
                    end
                end
            end

            ST_SD_LEFT: begin
                if (lc >= size_ext) begin
                    o_ram.we    = 1'b1;
                    o_ram.waddr = r_pos;
                    o_ram.wdata = r_val;
                    n_state     = ST_D_ROOT;
                end else begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = lc[ADDR_W-1:0];
                    n_state     = ST_SD_RIGHT;
                end
            end

            ST_SD_RIGHT: begin
                n_lval = i_rdata;
                if (rc < size_ext) begin
                    o_ram.re    = 1'b1;
                    o_ram.raddr = rc[ADDR_W-1:0];
                    n_has_rc    = 1'b1;
                end else begin
                    n_has_rc = 1'b0;
                end
                n_state = ST_SD_CMP;
            end

            ST_SD_CMP: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_pos;
                if (r_val < pick_val) begin
                    o_ram.wdata = r_val;
                    n_state     = ST_D_ROOT;
                end else begin
                    // Pull the smaller child up and follow it.
                    o_ram.wdata = pick_val;
                    n_pos       = pick_idx;
                    n_state     = ST_SD_LEFT;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // The fill count never passes the capacity.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("heap count beyond capacity");

    // A read and a write never hit the same entry in one cycle.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ram.we && o_ram.re && (o_ram.waddr == o_ram.raddr)))
        else $error("read and write to the same heap entry");

    // The final result of a run leaves the heap empty and clears overflow.
    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |=> (r_count == '0) && !r_ovf)
        else $error("heap not cleared after final result");

    // Results are only offered while the output side can take them and the heap is not empty.
    a_res_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> i_res_ready && (r_count != '0))
        else $error("result offered without room or data");
`endif

endmodule
